### rtl/stok_pkg.sv
`default_nettype none

package stok_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        MODE_SKIP    = 5'b00001,
        MODE_SLASH   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_QUOTED  = 5'b01000,
        MODE_WORD    = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic       token_end;
        logic       data_end;
    } result_t;

    // One entry per input word that produces output. A two-result entry is
    // always a held slash followed by an ordinary word byte.
    typedef struct packed {
        logic       two;
        result_t    first;
        logic [7:0] second_byte;
    } step_t;

endpackage

`default_nettype wire

### rtl/script_tokenizer_core.sv
// Streaming text tokenizer. Bytes enter on the char channel (char_in with
// char_valid/char_ready) and token results leave on the result channel
// (token_byte, byte_valid, token_end, data_end, last_of_step with
// result_valid/result_ready). Each word is accepted when valid and ready are
// both high at a rising edge of clk.
// The classifier updates the scan mode for each accepted byte and writes its
// results, if any, into a four-entry queue. The first result of a byte passes
// through a queue entry and then the output register. The classifier accepts
// one byte every cycle while the queue has room; the output register delivers
// one result per cycle while the receiver is ready, so a slash that opens a
// word, which yields two results, delivers both from a single queue entry.
// Bytes that yield no result (whitespace, comment text) never reach the
// queue.
// When the receiver stalls, the output register holds its result and the
// queue fills; char_ready falls once all four entries are taken.
// Reset (rst_n low, asynchronous) empties the queue and the output register
// and returns the scan mode to skipping whitespace. A NUL byte ends the
// data and returns the scan mode to skipping whitespace as well.
`default_nettype none

module script_tokenizer_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] char_in,
    input  wire logic       char_valid,
    output logic            char_ready,
    output logic [7:0]      token_byte,
    output logic            byte_valid,
    output logic            token_end,
    output logic            data_end,
    output logic            last_of_step,
    output logic            result_valid,
    input  wire logic       result_ready
);

    logic            queue_full;
    logic            queue_empty;
    logic            push;
    logic            pop;
    stok_pkg::step_t push_step;
    stok_pkg::step_t head_step;

    stok_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .queue_full (queue_full),
        .push       (push),
        .step       (push_step)
    );

    stok_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_step),
        .full    (queue_full),
        .rd_en   (pop),
        .rd_data (head_step),
        .empty   (queue_empty)
    );

    stok_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_step),
        .head_empty   (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .token_byte   (token_byte),
        .byte_valid   (byte_valid),
        .token_end    (token_end),
        .data_end     (data_end),
        .last_of_step (last_of_step)
    );

endmodule

`default_nettype wire

### rtl/stok_front.sv
`default_nettype none

module stok_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     char_in,
    input  wire logic           char_valid,
    output logic                char_ready,
    input  wire logic           queue_full,
    output logic                push,
    output stok_pkg::step_t     step
);

    stok_pkg::mode_t mode_reg;
    stok_pkg::mode_t mode_next;
    logic            has_result;
    logic            accept;
    logic            is_nul;
    logic            is_space;

    assign char_ready = !queue_full;
    assign accept     = char_valid && char_ready;
    assign is_nul     = (char_in == stok_pkg::CHAR_NUL);
    assign is_space   = (char_in <= stok_pkg::CHAR_SPACE);
    assign push       = accept && has_result;

    always_comb
    begin
        mode_next              = mode_reg;
        has_result             = 1'b0;
        step.two               = 1'b0;
        step.first.token_byte  = 8'h00;
        step.first.byte_valid  = 1'b0;
        step.first.token_end   = 1'b0;
        step.first.data_end    = 1'b0;
        step.second_byte       = char_in;
        case (mode_reg)
            stok_pkg::MODE_SLASH:
            begin
                if (char_in == stok_pkg::CHAR_SLASH)
                begin
                    mode_next = stok_pkg::MODE_COMMENT;
                end
                else
                begin
                    has_result            = 1'b1;
                    step.first.token_byte = stok_pkg::CHAR_SLASH;
                    step.first.byte_valid = 1'b1;
                    if (is_space)
                    begin
                        step.first.token_end = 1'b1;
                        step.first.data_end  = is_nul;
                        mode_next            = stok_pkg::MODE_SKIP;
                    end
                    else
                    begin
                        step.two  = 1'b1;
                        mode_next = stok_pkg::MODE_WORD;
                    end
                end
            end
            stok_pkg::MODE_COMMENT:
            begin
                if (is_nul)
                begin
                    has_result          = 1'b1;
                    step.first.data_end = 1'b1;
                    mode_next           = stok_pkg::MODE_SKIP;
                end
                else if (char_in == stok_pkg::CHAR_NL)
                begin
                    mode_next = stok_pkg::MODE_SKIP;
                end
            end
            stok_pkg::MODE_QUOTED:
            begin
                has_result = 1'b1;
                if (is_nul || char_in == stok_pkg::CHAR_QUOTE)
                begin
                    step.first.token_end = 1'b1;
                    step.first.data_end  = is_nul;
                    mode_next            = stok_pkg::MODE_SKIP;
                end
                else
                begin
                    step.first.token_byte = char_in;
                    step.first.byte_valid = 1'b1;
                end
            end
            stok_pkg::MODE_WORD:
            begin
                has_result = 1'b1;
                if (is_space)
                begin
                    step.first.token_end = 1'b1;
                    step.first.data_end  = is_nul;
                    mode_next            = stok_pkg::MODE_SKIP;
                end
                else
                begin
                    step.first.token_byte = char_in;
                    step.first.byte_valid = 1'b1;
                end
            end
            default:
            begin
                mode_next = stok_pkg::MODE_SKIP;
                if (is_nul)
                begin
                    has_result          = 1'b1;
                    step.first.data_end = 1'b1;
                end
                else if (is_space)
                begin
                    mode_next = stok_pkg::MODE_SKIP;
                end
                else if (char_in == stok_pkg::CHAR_SLASH)
                begin
                    mode_next = stok_pkg::MODE_SLASH;
                end
                else if (char_in == stok_pkg::CHAR_QUOTE)
                begin
                    mode_next = stok_pkg::MODE_QUOTED;
                end
                else
                begin
                    has_result            = 1'b1;
                    step.first.token_byte = char_in;
                    step.first.byte_valid = 1'b1;
                    mode_next             = stok_pkg::MODE_WORD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stok_pkg::MODE_SKIP;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

`default_nettype wire

### rtl/stok_queue.sv
`default_nettype none

module stok_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire stok_pkg::step_t wr_data,
    output logic                 full,
    input  wire logic            rd_en,
    output stok_pkg::step_t      rd_data,
    output logic                 empty
);

    stok_pkg::step_t                   entry_reg [stok_pkg::QUEUE_DEPTH];
    logic [stok_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [stok_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [stok_pkg::QUEUE_CW-1:0]     count_reg;
    logic [stok_pkg::QUEUE_CW-1:0]     count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign full    = (count_reg == stok_pkg::QUEUE_CW'(stok_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/stok_back.sv
`default_nettype none

module stok_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire stok_pkg::step_t head,
    input  wire logic            head_empty,
    output logic                 pop,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output logic [7:0]           token_byte,
    output logic                 byte_valid,
    output logic                 token_end,
    output logic                 data_end,
    output logic                 last_of_step
);

    logic             valid_reg;
    logic             half_reg;
    logic             half_next;
    stok_pkg::result_t res_reg;
    stok_pkg::result_t res_next;
    logic             last_reg;
    logic             last_next;
    logic             load;

    assign load = (!valid_reg || result_ready) && !head_empty;

    always_comb
    begin
        res_next  = head.first;
        last_next = 1'b1;
        half_next = 1'b0;
        pop       = load;
        if (head.two && !half_reg)
        begin
            last_next = 1'b0;
            half_next = 1'b1;
            pop       = 1'b0;
        end
        else if (head.two)
        begin
            res_next.token_byte = head.second_byte;
            res_next.byte_valid = 1'b1;
            res_next.token_end  = 1'b0;
            res_next.data_end   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                half_reg  <= half_next;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res_next;
            last_reg <= last_next;
        end
    end

    assign result_valid = valid_reg;
    assign token_byte   = res_reg.token_byte;
    assign byte_valid   = res_reg.byte_valid;
    assign token_end    = res_reg.token_end;
    assign data_end     = res_reg.data_end;
    assign last_of_step = last_reg;

endmodule

`default_nettype wire

### rtl/stok_checker.sv
`default_nettype none

module stok_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       result_valid,
    input  wire logic       result_ready,
    input  wire logic [7:0] token_byte,
    input  wire logic       byte_valid,
    input  wire logic       token_end,
    input  wire logic       data_end,
    input  wire logic       last_of_step
);

    // A stalled result keeps every field.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(token_byte) && $stable(byte_valid) &&
            $stable(token_end) && $stable(data_end) && $stable(last_of_step))
        else $error("result changed while stalled");

    // The end of the data is always the final result of its byte.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && data_end |-> last_of_step)
        else $error("data_end without last_of_step");

    // A result without a byte carries zero in the byte field.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> token_byte == 8'h00)
        else $error("token_byte set without byte_valid");

    // Every result carries a byte, ends a token or ends the data.
    a_content: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> byte_valid || token_end || data_end)
        else $error("empty result");

endmodule

bind script_tokenizer_core stok_checker u_stok_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .token_byte   (token_byte),
    .byte_valid   (byte_valid),
    .token_end    (token_end),
    .data_end     (data_end),
    .last_of_step (last_of_step)
);

`default_nettype wire

### sim/script_tokenizer_core_tb.sv
`default_nettype none

module script_tokenizer_core_tb;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic       token_end;
        logic       data_end;
        logic       last_of_step;
    } token_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic       one;
        logic [7:0] want_byte;
        logic       want_valid;
        logic       want_tend;
        logic       want_dend;
    } stim_row_t;

    localparam int BUSY_ITEMS   = 1750;
    localparam int STALL_LIMIT  = 4000;
    localparam int IDLE_PCT     = 32;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic [7:0] char_in = 8'h00;
    logic       char_valid = 1'b0;
    logic       char_ready;
    logic [7:0] token_byte;
    logic       byte_valid;
    logic       token_end;
    logic       data_end;
    logic       last_of_step;
    logic       result_valid;
    logic       result_ready = 1'b0;

    stok_pkg::mode_t tok_state = stok_pkg::MODE_SKIP;
    token_word_t pending_words[$];
    stim_row_t   script_rows[26];
    int          errors = 0;
    int          busy_items = 0;
    int          stall_cycles = 0;
    logic        calm = 1'b0;

    script_tokenizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_in      (char_in),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .token_byte   (token_byte),
        .byte_valid   (byte_valid),
        .token_end    (token_end),
        .data_end     (data_end),
        .last_of_step (last_of_step),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic token_word_t word_of(logic [7:0] b, logic v, logic te, logic de);
        token_word_t w;
        w.token_byte   = b;
        w.byte_valid   = v;
        w.token_end    = te;
        w.data_end     = de;
        w.last_of_step = 1'b0;
        return w;
    endfunction

    task automatic tokenize_char(input logic [7:0] c, output int n,
                                 output token_word_t w0, output token_word_t w1);
        n  = 0;
        w0 = '0;
        w1 = '0;
        case (tok_state)
            stok_pkg::MODE_SLASH:
            begin
                if (c == stok_pkg::CHAR_SLASH)
                begin
                    tok_state = stok_pkg::MODE_COMMENT;
                end
                else if (c == stok_pkg::CHAR_NUL)
                begin
                    w0 = word_of(stok_pkg::CHAR_SLASH, 1'b1, 1'b1, 1'b1);
                    n = 1;
                    tok_state = stok_pkg::MODE_SKIP;
                end
                else if (c <= stok_pkg::CHAR_SPACE)
                begin
                    w0 = word_of(stok_pkg::CHAR_SLASH, 1'b1, 1'b1, 1'b0);
                    n = 1;
                    tok_state = stok_pkg::MODE_SKIP;
                end
                else
                begin
                    w0 = word_of(stok_pkg::CHAR_SLASH, 1'b1, 1'b0, 1'b0);
                    w1 = word_of(c, 1'b1, 1'b0, 1'b0);
                    n = 2;
                    tok_state = stok_pkg::MODE_WORD;
                end
            end
            stok_pkg::MODE_COMMENT:
            begin
                if (c == stok_pkg::CHAR_NUL)
                begin
                    w0 = word_of(stok_pkg::CHAR_NUL, 1'b0, 1'b0, 1'b1);
                    n = 1;
                    tok_state = stok_pkg::MODE_SKIP;
                end
                else if (c == stok_pkg::CHAR_NL)
                begin
                    tok_state = stok_pkg::MODE_SKIP;
                end
            end
            stok_pkg::MODE_QUOTED:
            begin
                if (c == stok_pkg::CHAR_NUL)
                begin
                    w0 = word_of(stok_pkg::CHAR_NUL, 1'b0, 1'b1, 1'b1);
                    tok_state = stok_pkg::MODE_SKIP;
                end
                else if (c == stok_pkg::CHAR_QUOTE)
                begin
                    w0 = word_of(stok_pkg::CHAR_NUL, 1'b0, 1'b1, 1'b0);
                    tok_state = stok_pkg::MODE_SKIP;
                end
                else
                begin
                    w0 = word_of(c, 1'b1, 1'b0, 1'b0);
                end
                n = 1;
            end
            stok_pkg::MODE_WORD:
            begin
                if (c == stok_pkg::CHAR_NUL)
                begin
                    w0 = word_of(stok_pkg::CHAR_NUL, 1'b0, 1'b1, 1'b1);
                    tok_state = stok_pkg::MODE_SKIP;
                end
                else if (c <= stok_pkg::CHAR_SPACE)
                begin
                    w0 = word_of(stok_pkg::CHAR_NUL, 1'b0, 1'b1, 1'b0);
                    tok_state = stok_pkg::MODE_SKIP;
                end
                else
                begin
                    w0 = word_of(c, 1'b1, 1'b0, 1'b0);
                end
                n = 1;
            end
            default:
            begin
                if (c == stok_pkg::CHAR_NUL)
                begin
                    w0 = word_of(stok_pkg::CHAR_NUL, 1'b0, 1'b0, 1'b1);
                    n = 1;
                end
                else if (c <= stok_pkg::CHAR_SPACE)
                begin
                    n = 0;
                end
                else if (c == stok_pkg::CHAR_SLASH)
                begin
                    tok_state = stok_pkg::MODE_SLASH;
                end
                else if (c == stok_pkg::CHAR_QUOTE)
                begin
                    tok_state = stok_pkg::MODE_QUOTED;
                end
                else
                begin
                    w0 = word_of(c, 1'b1, 1'b0, 1'b0);
                    n = 1;
                    tok_state = stok_pkg::MODE_WORD;
                end
            end
        endcase
        if (n == 1)
            w0.last_of_step = 1'b1;
        else if (n == 2)
            w1.last_of_step = 1'b1;
    endtask

    task automatic send_char(input logic [7:0] c, input logic typed, input logic one,
                             input token_word_t want);
        int          gap;
        int          n;
        token_word_t w0;
        token_word_t w1;
        gap = 0;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        end
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_in    <= c;
        char_valid <= 1'b1;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        tokenize_char(c, n, w0, w1);
        if (typed)
        begin
            if (one)
            begin
                want.last_of_step = 1'b1;
                pending_words.push_back(want);
            end
        end
        else
        begin
            if (n >= 1)
                pending_words.push_back(w0);
            if (n == 2)
                pending_words.push_back(w1);
        end
        busy_items++;
    endtask

    task automatic send_plain(input logic [7:0] c);
        send_char(c, 1'b0, 1'b0, '0);
    endtask

    task automatic drain_results();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        int p;
        p = $urandom_range(0, 99);
        if (p < 2)
            return stok_pkg::CHAR_NUL;
        else if (p < 16)
            return 8'($urandom_range(1, 32));
        else if (p < 22)
            return stok_pkg::CHAR_SLASH;
        else if (p < 28)
            return stok_pkg::CHAR_QUOTE;
        else if (p < 32)
            return stok_pkg::CHAR_NL;
        return 8'($urandom_range(33, 255));
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        token_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h/%b%b%b%b", $time,
                         token_byte, byte_valid, token_end, data_end, last_of_step);
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("token_byte", want.token_byte, token_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
                check_field("token_end", 8'(want.token_end), 8'(token_end));
                check_field("data_end", 8'(want.data_end), 8'(data_end));
                check_field("last_of_step", 8'(want.last_of_step), 8'(last_of_step));
            end
        end
        result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int len;
        int next_drain;
        script_rows = '{
            '{8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1},
            '{8'h20, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0},
            '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h20, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
            '{8'h22, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h22, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
            '{8'h22, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
            '{8'h2F, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h61, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h0A, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
            '{8'h2F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h2F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1},
            '{8'h2F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h20, 1'b1, 1'b1, 8'h2F, 1'b1, 1'b1, 1'b0},
            '{8'h2F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h00, 1'b1, 1'b1, 8'h2F, 1'b1, 1'b1, 1'b1},
            '{8'h2F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h2F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h0A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h71, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 26; i++)
        begin
            send_char(script_rows[i].ch, script_rows[i].typed, script_rows[i].one,
                      word_of(script_rows[i].want_byte, script_rows[i].want_valid,
                              script_rows[i].want_tend, script_rows[i].want_dend));
        end
        drain_results();

        // Random text, with whole line comments mixed in so that the comment
        // mode is entered and left often.
        busy_items = 0;
        next_drain = 450;
        while (busy_items < BUSY_ITEMS)
        begin
            if (busy_items >= next_drain)
            begin
                drain_results();
                next_drain += 450;
            end
            calm = (busy_items >= 700 && busy_items < 1000);
            if ($urandom_range(0, 99) < 5)
            begin
                send_plain(stok_pkg::CHAR_SLASH);
                send_plain(stok_pkg::CHAR_SLASH);
                len = $urandom_range(0, 6);
                for (k = 0; k < len; k++)
                    send_plain(8'($urandom_range(1, 255)));
                send_plain(($urandom_range(0, 9) == 0) ? stok_pkg::CHAR_NUL
                                                       : stok_pkg::CHAR_NL);
            end
            else
            begin
                send_plain(pick_char());
            end
        end
        calm = 1'b0;
        char_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/stok_pkg.sv
rtl/stok_front.sv
rtl/stok_queue.sv
rtl/stok_back.sv
rtl/script_tokenizer_core.sv
rtl/stok_checker.sv
sim/script_tokenizer_core_tb.sv
